FILE: sv/assert_macros.svh
// assertion macros used by the scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_AT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression that must never hold
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_AT_CLK(label, !(expr), msg)

`endif

FILE: sv/mfq_pkg.sv
// types, sizes and codes of the multilevel feedback queue scheduler
`timescale 1ns / 1ps
`default_nettype none

package mfq_pkg;

  localparam int FIRST_DEPTH  = 16;
  localparam int SECOND_DEPTH = 32;
  localparam int THIRD_DEPTH  = 32;
  localparam int ID_WIDTH     = 16;

  localparam int BURST_W = 16;
  localparam int REM_W   = BURST_W + 1;
  localparam int ENTRY_W = BURST_W + ID_WIDTH;
  localparam int QUANT_W = 8;
  localparam int PICK_W  = 4;
  localparam int EV_W    = 3;
  localparam int SQ_W    = 2;

  // all three queues share one memory, one region each
  localparam int TOTAL_DEPTH = FIRST_DEPTH + SECOND_DEPTH + THIRD_DEPTH;
  localparam int ADDR_W      = $clog2(TOTAL_DEPTH);
  localparam int FIRST_BASE  = 0;
  localparam int SECOND_BASE = FIRST_DEPTH;
  localparam int THIRD_BASE  = FIRST_DEPTH + SECOND_DEPTH;

  localparam int F_HW = $clog2(FIRST_DEPTH);
  localparam int F_CW = $clog2(FIRST_DEPTH + 1);
  localparam int S_HW = $clog2(SECOND_DEPTH);
  localparam int S_CW = $clog2(SECOND_DEPTH + 1);
  localparam int T_HW = $clog2(THIRD_DEPTH);
  localparam int T_CW = $clog2(THIRD_DEPTH + 1);

  // wide enough for any fill count and any limit register
  localparam int CMP_W = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_FIRST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_SECOND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_FIRST_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_SECOND_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROMOTE_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FIRST        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SECOND       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THIRD        = 3'd7;

  // actions
  localparam logic ACT_ADMIT = 1'b0;
  localparam logic ACT_SCHED = 1'b1;

  // result events
  localparam logic [EV_W-1:0] EV_ADMITTED  = 3'd0;
  localparam logic [EV_W-1:0] EV_REJECTED  = 3'd1;
  localparam logic [EV_W-1:0] EV_TO_SECOND = 3'd2;
  localparam logic [EV_W-1:0] EV_PROMOTED  = 3'd3;
  localparam logic [EV_W-1:0] EV_DEMOTED   = 3'd4;
  localparam logic [EV_W-1:0] EV_FINISHED  = 3'd5;
  localparam logic [EV_W-1:0] EV_DROPPED   = 3'd6;
  localparam logic [EV_W-1:0] EV_IDLE      = 3'd7;

  // queue codes
  localparam logic [SQ_W-1:0] SQ_NONE   = 2'd0;
  localparam logic [SQ_W-1:0] SQ_FIRST  = 2'd1;
  localparam logic [SQ_W-1:0] SQ_SECOND = 2'd2;
  localparam logic [SQ_W-1:0] SQ_THIRD  = 2'd3;

  typedef struct packed {
    logic [QUANT_W-1:0] quantum_first;
    logic [QUANT_W-1:0] quantum_second;
    logic [3:0]         share_first_limit;
    logic [3:0]         share_second_limit;
    logic [3:0]         promote_limit;
    logic [4:0]         limit_first;
    logic [5:0]         limit_second;
    logic [5:0]         limit_third;
  } cfg_t;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: sv/mfq_cfg.sv
// configuration registers of the scheduler
`timescale 1ns / 1ps
`default_nettype none

module mfq_cfg import mfq_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quantum_first      <= 8'd8;
      cfg_q.quantum_second     <= 8'd16;
      cfg_q.share_first_limit  <= 4'd5;
      cfg_q.share_second_limit <= 4'd8;
      cfg_q.promote_limit      <= 4'd5;
      cfg_q.limit_first        <= 5'd10;
      cfg_q.limit_second       <= 6'd20;
      cfg_q.limit_third        <= 6'd30;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_QUANTUM_FIRST:      cfg_q.quantum_first      <= cfg_data_i;
        REG_QUANTUM_SECOND:     cfg_q.quantum_second     <= cfg_data_i;
        REG_SHARE_FIRST_LIMIT:  cfg_q.share_first_limit  <= cfg_data_i[3:0];
        REG_SHARE_SECOND_LIMIT: cfg_q.share_second_limit <= cfg_data_i[3:0];
        REG_PROMOTE_LIMIT:      cfg_q.promote_limit      <= cfg_data_i[3:0];
        REG_LIMIT_FIRST:        cfg_q.limit_first        <= cfg_data_i[4:0];
        REG_LIMIT_SECOND:       cfg_q.limit_second       <= cfg_data_i[5:0];
        REG_LIMIT_THIRD:        cfg_q.limit_third        <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfq_store.sv
// shared queue memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module mfq_store import mfq_pkg::*; (
  input  wire logic         clk_i,
  input  wire mem_req_t     req_i,
  output logic [ENTRY_W-1:0] rd_data_o
);

  logic [ENTRY_W-1:0] mem [TOTAL_DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/mfq_core.sv
// queue pointers, scheduling decision and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
`default_nettype none

module mfq_core import mfq_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  action_i,
  input  wire logic [ID_WIDTH-1:0]   job_id_i,
  input  wire logic [BURST_W-1:0]    burst_length_i,
  input  wire logic [PICK_W-1:0]     queue_pick_i,
  input  wire logic [PICK_W-1:0]     route_pick_i,
  output mem_req_t                   mem_req_o,
  input  wire logic [ENTRY_W-1:0]    rd_data_i,
  output logic                       res_valid_o,
  output logic [EV_W-1:0]            event_res_o,
  output logic [ID_WIDTH-1:0]        result_id_o,
  output logic signed [REM_W-1:0]    remaining_o,
  output logic [SQ_W-1:0]            served_queue_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;

  logic [F_HW-1:0] f_head_q;
  logic [F_CW-1:0] f_cnt_q;
  logic [S_HW-1:0] s_head_q;
  logic [S_CW-1:0] s_cnt_q;
  logic [T_HW-1:0] t_head_q;
  logic [T_CW-1:0] t_cnt_q;

  // item captured at accept
  logic                action_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [BURST_W-1:0]  burst_q;
  logic [PICK_W-1:0]   rpick_q;
  logic [SQ_W-1:0]     sel_q, sel_d;

  logic                res_valid_q;
  logic [EV_W-1:0]     ev_q, ev_d;
  logic [ID_WIDTH-1:0] rid_q, rid_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [SQ_W-1:0]     sq_q, sq_d;

  logic accept;
  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q == ST_BUSY);

  // tail positions, head plus count wrapped once
  logic [F_CW:0]   f_sum;
  logic [S_CW:0]   s_sum;
  logic [T_CW:0]   t_sum;
  logic [F_HW-1:0] f_tail;
  logic [S_HW-1:0] s_tail;
  logic [T_HW-1:0] t_tail;

  always_comb begin
    f_sum  = (F_CW + 1)'(f_head_q) + (F_CW + 1)'(f_cnt_q);
    s_sum  = (S_CW + 1)'(s_head_q) + (S_CW + 1)'(s_cnt_q);
    t_sum  = (T_CW + 1)'(t_head_q) + (T_CW + 1)'(t_cnt_q);
    f_tail = (f_sum >= (F_CW + 1)'(FIRST_DEPTH)) ?
             F_HW'(f_sum - (F_CW + 1)'(FIRST_DEPTH)) : F_HW'(f_sum);
    s_tail = (s_sum >= (S_CW + 1)'(SECOND_DEPTH)) ?
             S_HW'(s_sum - (S_CW + 1)'(SECOND_DEPTH)) : S_HW'(s_sum);
    t_tail = (t_sum >= (T_CW + 1)'(THIRD_DEPTH)) ?
             T_HW'(t_sum - (T_CW + 1)'(THIRD_DEPTH)) : T_HW'(t_sum);
  end

  // limit zero or above depth handled by the two compares
  logic f_full, s_full, t_full;
  assign f_full = (CMP_W'(f_cnt_q) >= CMP_W'(cfg_i.limit_first)) ||
                  (CMP_W'(f_cnt_q) >= CMP_W'(FIRST_DEPTH));
  assign s_full = (CMP_W'(s_cnt_q) >= CMP_W'(cfg_i.limit_second)) ||
                  (CMP_W'(s_cnt_q) >= CMP_W'(SECOND_DEPTH));
  assign t_full = (CMP_W'(t_cnt_q) >= CMP_W'(cfg_i.limit_third)) ||
                  (CMP_W'(t_cnt_q) >= CMP_W'(THIRD_DEPTH));

  // queue choice at accept, the head read goes out at the same edge
  always_comb begin
    sel_d = SQ_NONE;
    if (action_i == ACT_SCHED) begin
      if ((queue_pick_i <= cfg_i.share_first_limit) && (f_cnt_q != '0)) begin
        sel_d = SQ_FIRST;
      end else if ((queue_pick_i > cfg_i.share_first_limit) &&
                   (queue_pick_i <= cfg_i.share_second_limit) &&
                   (s_cnt_q != '0)) begin
        sel_d = SQ_SECOND;
      end else if (t_cnt_q != '0) begin
        sel_d = SQ_THIRD;
      end
    end
  end

  logic [ADDR_W-1:0] rd_addr;
  always_comb begin
    case (sel_d)
      SQ_FIRST:  rd_addr = ADDR_W'(FIRST_BASE) + ADDR_W'(f_head_q);
      SQ_SECOND: rd_addr = ADDR_W'(SECOND_BASE) + ADDR_W'(s_head_q);
      SQ_THIRD:  rd_addr = ADDR_W'(THIRD_BASE) + ADDR_W'(t_head_q);
      default:   rd_addr = '0;
    endcase
  end

  // work cycle: head entry is on rd_data_i
  logic [ID_WIDTH-1:0] ent_id;
  logic [BURST_W-1:0]  ent_burst;
  logic [REM_W-1:0]    rem_first, rem_second;
  logic                pos_first, pos_second, promote;

  assign ent_id     = rd_data_i[ID_WIDTH-1:0];
  assign ent_burst  = rd_data_i[ENTRY_W-1:ID_WIDTH];
  assign rem_first  = {1'b0, ent_burst} - REM_W'(cfg_i.quantum_first);
  assign rem_second = {1'b0, ent_burst} - REM_W'(cfg_i.quantum_second);
  assign pos_first  = !rem_first[REM_W-1] && (rem_first != '0);
  assign pos_second = !rem_second[REM_W-1] && (rem_second != '0);
  assign promote    = (rpick_q != '0) && (rpick_q <= cfg_i.promote_limit);

  logic [SQ_W-1:0]    tgt;
  logic [ENTRY_W-1:0] push_entry;
  logic               tgt_full;
  logic               f_pop, s_pop, t_pop;

  always_comb begin
    tgt        = SQ_NONE;
    push_entry = {ent_burst, ent_id};
    f_pop      = 1'b0;
    s_pop      = 1'b0;
    t_pop      = 1'b0;
    ev_d       = EV_IDLE;
    rid_d      = '0;
    rem_d      = '0;
    sq_d       = SQ_NONE;
    if (action_q == ACT_ADMIT) begin
      tgt        = SQ_FIRST;
      push_entry = {burst_q, id_q};
      rid_d      = id_q;
      rem_d      = {1'b0, burst_q};
    end else begin
      case (sel_q)
        SQ_FIRST: begin
          f_pop      = 1'b1;
          rid_d      = ent_id;
          rem_d      = rem_first;
          sq_d       = SQ_FIRST;
          push_entry = {rem_first[BURST_W-1:0], ent_id};
          tgt        = pos_first ? SQ_SECOND : SQ_NONE;
        end
        SQ_SECOND: begin
          s_pop      = 1'b1;
          rid_d      = ent_id;
          rem_d      = rem_second;
          sq_d       = SQ_SECOND;
          push_entry = {rem_second[BURST_W-1:0], ent_id};
          if (pos_second) begin
            tgt = promote ? SQ_FIRST : SQ_THIRD;
          end
        end
        SQ_THIRD: begin
          t_pop = 1'b1;
          rid_d = ent_id;
          rem_d = {1'b0, ent_burst};
          sq_d  = SQ_THIRD;
        end
        default: begin
        end
      endcase
    end

    case (tgt)
      SQ_FIRST:  tgt_full = f_full;
      SQ_SECOND: tgt_full = s_full;
      SQ_THIRD:  tgt_full = t_full;
      default:   tgt_full = 1'b0;
    endcase

    if (action_q == ACT_ADMIT) begin
      ev_d = tgt_full ? EV_REJECTED : EV_ADMITTED;
    end else if (sel_q != SQ_NONE) begin
      if (tgt == SQ_NONE) begin
        ev_d = EV_FINISHED;
      end else if (tgt_full) begin
        ev_d = EV_DROPPED;
      end else if (sel_q == SQ_FIRST) begin
        ev_d = EV_TO_SECOND;
      end else if (tgt == SQ_FIRST) begin
        ev_d = EV_PROMOTED;
      end else begin
        ev_d = EV_DEMOTED;
      end
    end
  end

  logic              do_push;
  logic [ADDR_W-1:0] wr_addr;
  assign do_push = busy_o && (tgt != SQ_NONE) && !tgt_full;

  always_comb begin
    case (tgt)
      SQ_FIRST:  wr_addr = ADDR_W'(FIRST_BASE) + ADDR_W'(f_tail);
      SQ_SECOND: wr_addr = ADDR_W'(SECOND_BASE) + ADDR_W'(s_tail);
      SQ_THIRD:  wr_addr = ADDR_W'(THIRD_BASE) + ADDR_W'(t_tail);
      default:   wr_addr = '0;
    endcase
  end

  assign mem_req_o.rd_en   = accept && (sel_d != SQ_NONE);
  assign mem_req_o.rd_addr = rd_addr;
  assign mem_req_o.wr_en   = do_push;
  assign mem_req_o.wr_addr = wr_addr;
  assign mem_req_o.wr_data = push_entry;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_BUSY;
      ST_BUSY: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      f_head_q    <= '0;
      f_cnt_q     <= '0;
      s_head_q    <= '0;
      s_cnt_q     <= '0;
      t_head_q    <= '0;
      t_cnt_q     <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= busy_o;
      if (busy_o) begin
        if (f_pop) begin
          f_head_q <= (f_head_q == F_HW'(FIRST_DEPTH - 1)) ? '0 : f_head_q + 1'b1;
          f_cnt_q  <= f_cnt_q - 1'b1;
        end else if (do_push && (tgt == SQ_FIRST)) begin
          f_cnt_q <= f_cnt_q + 1'b1;
        end
        if (s_pop) begin
          s_head_q <= (s_head_q == S_HW'(SECOND_DEPTH - 1)) ? '0 : s_head_q + 1'b1;
          s_cnt_q  <= s_cnt_q - 1'b1;
        end else if (do_push && (tgt == SQ_SECOND)) begin
          s_cnt_q <= s_cnt_q + 1'b1;
        end
        if (t_pop) begin
          t_head_q <= (t_head_q == T_HW'(THIRD_DEPTH - 1)) ? '0 : t_head_q + 1'b1;
          t_cnt_q  <= t_cnt_q - 1'b1;
        end else if (do_push && (tgt == SQ_THIRD)) begin
          t_cnt_q <= t_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      id_q     <= job_id_i;
      burst_q  <= burst_length_i;
      rpick_q  <= route_pick_i;
      sel_q    <= sel_d;
    end
    if (busy_o) begin
      ev_q  <= ev_d;
      rid_q <= rid_d;
      rem_q <= rem_d;
      sq_q  <= sq_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign event_res_o    = ev_q;
  assign result_id_o    = rid_q;
  assign remaining_o    = $signed(rem_q);
  assign served_queue_o = sq_q;

  `ASSERT_AT_CLK(a_res_follows_work, busy_o |=> res_valid_o, "result strobe missing after work")
  `ASSERT_NEVER(a_write_outside_work, mem_req_o.wr_en && !busy_o, "queue write outside work cycle")
  `ASSERT_AT_CLK(a_read_at_accept, mem_req_o.rd_en |-> (start_i && !busy_o), "head read without accept")
  `ASSERT_NEVER(a_pop_empty, busy_o && ((f_pop && (f_cnt_q == '0)) || (s_pop && (s_cnt_q == '0)) || (t_pop && (t_cnt_q == '0))), "pop from empty queue")
  `ASSERT_NEVER(a_count_over_depth, (CMP_W'(f_cnt_q) > CMP_W'(FIRST_DEPTH)) || (CMP_W'(s_cnt_q) > CMP_W'(SECOND_DEPTH)) || (CMP_W'(t_cnt_q) > CMP_W'(THIRD_DEPTH)), "queue count beyond depth")

endmodule

`default_nettype wire

FILE: sv/multilevel_feedback_queue_scheduler.sv
// top level of the three-level feedback queue scheduler
`timescale 1ns / 1ps
`default_nettype none

// For each item, start is taken while busy is low, the next cycle (busy high) takes
// the chosen queue head out of the registered read port of the shared queue
// memory and writes the moved job back, and the cycle after that shows the single
// result with res_valid_o high for exactly one cycle, while a new item may already
// start. The receiver cannot stall, so results must be taken when strobed.
// Configuration writes are always ready and are meant for idle periods only; no
// clearing pass runs after reset.
module multilevel_feedback_queue_scheduler import mfq_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  action_i,
  input  wire logic [ID_WIDTH-1:0]   job_id_i,
  input  wire logic [BURST_W-1:0]    burst_length_i,
  input  wire logic [PICK_W-1:0]     queue_pick_i,
  input  wire logic [PICK_W-1:0]     route_pick_i,
  output logic                       res_valid_o,
  output logic [EV_W-1:0]            event_res_o,
  output logic [ID_WIDTH-1:0]        result_id_o,
  output logic signed [REM_W-1:0]    remaining_o,
  output logic [SQ_W-1:0]            served_queue_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t               cfg;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rd_data;

  mfq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mfq_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  mfq_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start_i        (start),
    .busy_o         (busy),
    .action_i       (action_i),
    .job_id_i       (job_id_i),
    .burst_length_i (burst_length_i),
    .queue_pick_i   (queue_pick_i),
    .route_pick_i   (route_pick_i),
    .mem_req_o      (mem_req),
    .rd_data_i      (rd_data),
    .res_valid_o    (res_valid_o),
    .event_res_o    (event_res_o),
    .result_id_o    (result_id_o),
    .remaining_o    (remaining_o),
    .served_queue_o (served_queue_o)
  );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// self-checking testbench for the three-level feedback queue scheduler
`timescale 1ns / 1ps

module tb;
  import mfq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int BLOCKS_PER_PHASE = 6;
  localparam int ITEMS_PER_BLOCK = 18;

  typedef struct packed {
    logic                action;
    logic [ID_WIDTH-1:0] job_id;
    logic [BURST_W-1:0]  burst;
    logic [PICK_W-1:0]   queue_pick;
    logic [PICK_W-1:0]   route_pick;
  } sched_item_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [BURST_W-1:0]  burst;
  } queued_job_t;

  typedef struct packed {
    logic [EV_W-1:0]         ev;
    logic [ID_WIDTH-1:0]     id;
    logic signed [REM_W-1:0] rem;
    logic [SQ_W-1:0]         sq;
  } sched_outcome_t;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
    REG_QUANTUM_FIRST, REG_QUANTUM_SECOND, REG_SHARE_FIRST_LIMIT, REG_SHARE_SECOND_LIMIT,
    REG_PROMOTE_LIMIT, REG_LIMIT_FIRST, REG_LIMIT_SECOND, REG_LIMIT_THIRD
  };

  class mfq_scoreboard;
    cfg_t           regs;
    queued_job_t    lvl_first[$];
    queued_job_t    lvl_second[$];
    queued_job_t    lvl_third[$];
    sched_outcome_t due_outcomes[$];
    int             mismatches;

    function new();
      regs.quantum_first      = 8'd8;
      regs.quantum_second     = 8'd16;
      regs.share_first_limit  = 4'd5;
      regs.share_second_limit = 4'd8;
      regs.promote_limit      = 4'd5;
      regs.limit_first        = 5'd10;
      regs.limit_second       = 6'd20;
      regs.limit_third        = 6'd30;
      mismatches = 0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_QUANTUM_FIRST:      regs.quantum_first = data;
        REG_QUANTUM_SECOND:     regs.quantum_second = data;
        REG_SHARE_FIRST_LIMIT:  regs.share_first_limit = data[3:0];
        REG_SHARE_SECOND_LIMIT: regs.share_second_limit = data[3:0];
        REG_PROMOTE_LIMIT:      regs.promote_limit = data[3:0];
        REG_LIMIT_FIRST:        regs.limit_first = data[4:0];
        REG_LIMIT_SECOND:       regs.limit_second = data[5:0];
        REG_LIMIT_THIRD:        regs.limit_third = data[5:0];
        default: ;
      endcase
    endfunction

    // a limit above the queue depth saturates to the depth, zero means always full
    function bit enqueue(logic [SQ_W-1:0] lvl, queued_job_t j);
      int cap;
      case (lvl)
        SQ_FIRST: begin
          cap = (regs.limit_first < FIRST_DEPTH) ? int'(regs.limit_first) : FIRST_DEPTH;
          if (lvl_first.size() >= cap) return 1'b0;
          lvl_first.push_back(j);
        end
        SQ_SECOND: begin
          cap = (regs.limit_second < SECOND_DEPTH) ? int'(regs.limit_second) : SECOND_DEPTH;
          if (lvl_second.size() >= cap) return 1'b0;
          lvl_second.push_back(j);
        end
        default: begin
          cap = (regs.limit_third < THIRD_DEPTH) ? int'(regs.limit_third) : THIRD_DEPTH;
          if (lvl_third.size() >= cap) return 1'b0;
          lvl_third.push_back(j);
        end
      endcase
      return 1'b1;
    endfunction

    function void take_item(sched_item_t it);
      sched_outcome_t r;
      queued_job_t    j;
      queued_job_t    moved;
      int             left;
      r.ev  = EV_IDLE;
      r.id  = '0;
      r.rem = '0;
      r.sq  = SQ_NONE;
      if (it.action == ACT_ADMIT) begin
        j.id    = it.job_id;
        j.burst = it.burst;
        r.ev  = enqueue(SQ_FIRST, j) ? EV_ADMITTED : EV_REJECTED;
        r.id  = it.job_id;
        r.rem = {1'b0, it.burst};
      end else if (it.queue_pick <= regs.share_first_limit && lvl_first.size() != 0) begin
        j = lvl_first.pop_front();
        left = int'(j.burst) - int'(regs.quantum_first);
        r.id  = j.id;
        r.rem = left[REM_W-1:0];
        r.sq  = SQ_FIRST;
        moved.id    = j.id;
        moved.burst = left[BURST_W-1:0];
        if (left <= 0) r.ev = EV_FINISHED;
        else r.ev = enqueue(SQ_SECOND, moved) ? EV_TO_SECOND : EV_DROPPED;
      end else if (it.queue_pick > regs.share_first_limit &&
                   it.queue_pick <= regs.share_second_limit && lvl_second.size() != 0) begin
        j = lvl_second.pop_front();
        left = int'(j.burst) - int'(regs.quantum_second);
        r.id  = j.id;
        r.rem = left[REM_W-1:0];
        r.sq  = SQ_SECOND;
        moved.id    = j.id;
        moved.burst = left[BURST_W-1:0];
        if (left <= 0) begin
          r.ev = EV_FINISHED;
        end else if (it.route_pick >= 1 && it.route_pick <= regs.promote_limit) begin
          r.ev = enqueue(SQ_FIRST, moved) ? EV_PROMOTED : EV_DROPPED;
        end else begin
          r.ev = enqueue(SQ_THIRD, moved) ? EV_DEMOTED : EV_DROPPED;
        end
      end else if (lvl_third.size() != 0) begin
        // chosen queue empty or third chosen: run the third queue head to completion
        j = lvl_third.pop_front();
        r.ev  = EV_FINISHED;
        r.id  = j.id;
        r.rem = {1'b0, j.burst};
        r.sq  = SQ_THIRD;
      end
      due_outcomes.push_back(r);
    endfunction

    function void check_outcome(sched_outcome_t got);
      sched_outcome_t want;
      if (due_outcomes.size() == 0) begin
        report($sformatf("unexpected result event %0d id %h", got.ev, got.id));
        return;
      end
      want = due_outcomes.pop_front();
      if (got.ev !== want.ev)
        report($sformatf("event %0d, expected %0d (id %h)", got.ev, want.ev, want.id));
      if (got.id !== want.id)
        report($sformatf("result id %h, expected %h", got.id, want.id));
      if (got.rem !== want.rem)
        report($sformatf("remaining %0d, expected %0d (id %h)", got.rem, want.rem, want.id));
      if (got.sq !== want.sq)
        report($sformatf("served queue %0d, expected %0d (id %h)", got.sq, want.sq, want.id));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  action_i = ACT_ADMIT;
  logic [ID_WIDTH-1:0]   job_id_i = '0;
  logic [BURST_W-1:0]    burst_length_i = '0;
  logic [PICK_W-1:0]     queue_pick_i = '0;
  logic [PICK_W-1:0]     route_pick_i = '0;
  logic                  res_valid_o;
  logic [EV_W-1:0]       event_res_o;
  logic [ID_WIDTH-1:0]   result_id_o;
  logic signed [REM_W-1:0] remaining_o;
  logic [SQ_W-1:0]       served_queue_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mfq_scoreboard sb;
  bit            steady = 1'b0;
  int unsigned   cycles = 0;

  multilevel_feedback_queue_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .job_id_i       (job_id_i),
    .burst_length_i (burst_length_i),
    .queue_pick_i   (queue_pick_i),
    .route_pick_i   (route_pick_i),
    .res_valid_o    (res_valid_o),
    .event_res_o    (event_res_o),
    .result_id_o    (result_id_o),
    .remaining_o    (remaining_o),
    .served_queue_o (served_queue_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // results are strobed for one cycle and cannot be held off
  always @(posedge clk_i) begin : result_monitor
    sched_outcome_t seen;
    if (rst_ni && res_valid_o) begin
      seen.ev  = event_res_o;
      seen.id  = result_id_o;
      seen.rem = remaining_o;
      seen.sq  = served_queue_o;
      sb.check_outcome(seen);
    end
  end

  function automatic sched_item_t admit(logic [ID_WIDTH-1:0] id, logic [BURST_W-1:0] burst);
    sched_item_t it;
    it.action     = ACT_ADMIT;
    it.job_id     = id;
    it.burst      = burst;
    it.queue_pick = $urandom();
    it.route_pick = $urandom();
    return it;
  endfunction

  function automatic sched_item_t sched(logic [PICK_W-1:0] qp, logic [PICK_W-1:0] rp);
    sched_item_t it;
    it.action     = ACT_SCHED;
    it.job_id     = $urandom();
    it.burst      = $urandom();
    it.queue_pick = qp;
    it.route_pick = rp;
    return it;
  endfunction

  function automatic sched_item_t random_item(int admit_pct);
    sched_item_t it;
    it.action = ($urandom_range(99) < admit_pct) ? ACT_ADMIT : ACT_SCHED;
    it.job_id = $urandom();
    case ($urandom_range(19))
      0:       it.burst = '0;
      1, 2:    it.burst = $urandom();
      default: it.burst = $urandom_range(1, 600);
    endcase
    it.queue_pick = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
    it.route_pick = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
    return it;
  endfunction

  task automatic send_item(sched_item_t it);
    if (!steady && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start          <= 1'b1;
    action_i       <= it.action;
    job_id_i       <= it.job_id;
    burst_length_i <= it.burst;
    queue_pick_i   <= it.queue_pick;
    route_pick_i   <= it.route_pick;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.take_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.due_outcomes.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      if (!steady && $urandom_range(99) < 10) begin
        cfg_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= REG_ORDER[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(REG_ORDER[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] setting [8];
    int                    admit_pct;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk a few jobs through all three levels with the reset settings
    send_item(sched(4'd1, 4'd1));
    send_item(admit(16'h0000, 16'h0000));
    send_item(admit(16'hFFFF, 16'hFFFF));
    send_item(admit(16'h1234, 16'd20));
    send_item(admit(16'h5A5A, 16'd30));
    send_item(admit(16'h00FF, 16'd8));
    send_item(sched(4'd0, 4'd1));
    send_item(sched(4'd5, 4'd15));
    send_item(sched(4'd1, 4'd0));
    send_item(sched(4'd6, 4'd0));
    send_item(sched(4'd8, 4'd5));
    send_item(sched(4'd2, 4'd3));
    send_item(sched(4'd7, 4'd1));
    send_item(sched(4'd9, 4'd10));
    send_item(sched(4'd15, 4'd15));
    send_item(sched(4'd11, 4'd6));
    send_item(sched(4'd3, 4'd10));
    send_item(sched(4'd4, 4'd10));
    send_item(sched(4'd10, 4'd1));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setting = '{8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1};
        1: setting = '{8'd255, 8'd255, 8'd10, 8'd10, 8'd10, 8'd16, 8'd32, 8'd32};
        // upper data bits are dropped by the narrower registers
        2: setting = '{8'd3, 8'd200, 8'hFF, 8'hF0, 8'h0F, 8'd31, 8'd63, 8'hC0};
        3: setting = '{8'd0, 8'd0, 8'd3, 8'h1C, 8'd2, 8'h00, 8'hE0, 8'h7F};
        7: setting = '{8'd8, 8'd16, 8'd5, 8'd8, 8'd5, 8'd10, 8'd20, 8'd30};
        default: begin
          setting[0] = $urandom_range(1, 255);
          setting[1] = $urandom_range(1, 255);
          setting[2] = $urandom_range(0, 10);
          setting[3] = $urandom_range(0, 10);
          setting[4] = $urandom_range(0, 10);
          setting[5] = $urandom_range(1, 16);
          setting[6] = $urandom_range(1, 32);
          setting[7] = $urandom_range(1, 32);
        end
      endcase
      steady = (phase == 2);
      write_regs(setting);
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        // vary the admit share per block so queues reach both empty and full
        case ($urandom_range(3))
          0:       admit_pct = 25;
          1:       admit_pct = 50;
          2:       admit_pct = 75;
          default: admit_pct = 90;
        endcase
        for (int n = 0; n < ITEMS_PER_BLOCK; n++) send_item(random_item(admit_pct));
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
